// ----- rtl/sdftlp_pkg.sv -----
// Shared types, sizes and twiddle table for the sliding DFT low-pass filter.
// No dependencies; used by the filter core.

package sdftlp_pkg;

	// Window, bin and axis geometry
	localparam int WINDOW     = 32;
	localparam int MAX_BINS   = 8;
	localparam int AXES       = 3;
	localparam int POS_W      = $clog2(WINDOW);
	localparam int BIN_IDX_W  = $clog2(MAX_BINS);
	localparam int AXIS_W     = 2;
	localparam int HIST_DEPTH = AXES * WINDOW;
	localparam int BIN_DEPTH  = AXES * MAX_BINS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int BIN_AW     = $clog2(BIN_DEPTH);

	// Fixed-point widths
	localparam int SMP_W   = 16;
	localparam int TW_W    = 16;
	localparam int BIN_W   = 40;
	localparam int DELTA_W = SMP_W + 1 + 8;
	localparam int PROD_W  = BIN_W + TW_W;
	localparam int ACC_W   = 62;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HIST,
		ST_LOAD,
		ST_P_AC,
		ST_P_BD,
		ST_P_AD,
		ST_P_BC,
		ST_P_RC,
		ST_P_ID,
		ST_ACC,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Q1.15 cosine of 2*pi*k/WINDOW
	function automatic logic signed [TW_W-1:0] tw_cos(input logic [BIN_IDX_W-1:0] k);
		logic signed [TW_W-1:0] v;
		unique case (k)
			3'd0: v = 16'sd32767;
			3'd1: v = 16'sd32138;
			3'd2: v = 16'sd30274;
			3'd3: v = 16'sd27246;
			3'd4: v = 16'sd23170;
			3'd5: v = 16'sd18205;
			3'd6: v = 16'sd12540;
			3'd7: v = 16'sd6393;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Q1.15 sine of 2*pi*k/WINDOW
	function automatic logic signed [TW_W-1:0] tw_sin(input logic [BIN_IDX_W-1:0] k);
		logic signed [TW_W-1:0] v;
		unique case (k)
			3'd0: v = 16'sd0;
			3'd1: v = 16'sd6393;
			3'd2: v = 16'sd12540;
			3'd3: v = 16'sd18205;
			3'd4: v = 16'sd23170;
			3'd5: v = 16'sd27246;
			3'd6: v = 16'sd30274;
			3'd7: v = 16'sd32138;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/sdftlp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module sdftlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/sliding_dft_lowpass_filter_core.sv -----
// Sliding DFT low-pass filter core: sequencer, shared multiplier, history and bin RAMs.
// Depends on sdftlp_pkg and sdftlp_ram.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_wdata[2:0]  (highest_bin)
// in        in         in_valid / in_ready    sample[15:0] signed, axis[1:0]
// out       out        out_valid / out_ready  filtered[15:0] signed
//
// Each item on axis 0..2 is run to its end before the next is accepted; each kept
// bin above 0 runs eight steps through the one 40x16 multiplier, and highest_bin
// resets to 2. An item on axis 3 skips the bins and gives a zero result.
// Reset clears history and bins at once through per-entry valid bits; no sweep.
// A finished result sits in the output register; the next item is accepted while
// it waits, and the core stalls at its end only if that register is still full.

module sliding_dft_lowpass_filter_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [2:0]                             cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [sdftlp_pkg::SMP_W-1:0]    sample,
	input  logic [sdftlp_pkg::AXIS_W-1:0]          axis,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [sdftlp_pkg::SMP_W-1:0]    filtered
);

	localparam int SAT_W = sdftlp_pkg::BIN_W + 2;
	localparam int RND_W = sdftlp_pkg::PROD_W + 1;
	localparam int FIN_W = sdftlp_pkg::ACC_W + 1;
	localparam logic signed [SAT_W-1:0] BIN_HI = 42'sd549755813887;
	localparam logic signed [SAT_W-1:0] BIN_LO = -42'sd549755813888;

	// Clamp a widened bin value back to 40 bits
	function automatic logic signed [sdftlp_pkg::BIN_W-1:0] sat_bin(
		input logic signed [SAT_W-1:0] v
	);
		logic signed [sdftlp_pkg::BIN_W-1:0] r;
		if (v > BIN_HI) begin
			r = BIN_HI[sdftlp_pkg::BIN_W-1:0];
		end else if (v < BIN_LO) begin
			r = BIN_LO[sdftlp_pkg::BIN_W-1:0];
		end else begin
			r = v[sdftlp_pkg::BIN_W-1:0];
		end
		return r;
	endfunction

	sdftlp_pkg::state_t state_q, state_d;

	// Control registers
	logic [2:0]                          highest_bin_q;
	logic [sdftlp_pkg::POS_W-1:0]        position_q;
	logic [sdftlp_pkg::HIST_DEPTH-1:0]   hist_vld_q;
	logic [sdftlp_pkg::BIN_DEPTH-1:0]    bin_vld_q;
	logic                                out_valid_q;

	// Item registers
	logic signed [sdftlp_pkg::SMP_W-1:0]   smp_q;
	logic [sdftlp_pkg::AXIS_W-1:0]         axis_q;
	logic [2:0]                            hb_q;
	logic [sdftlp_pkg::HIST_AW-1:0]        hidx_q;
	logic [sdftlp_pkg::BIN_AW-1:0]         baddr_q;
	logic [sdftlp_pkg::BIN_IDX_W-1:0]      k_q;
	logic signed [sdftlp_pkg::DELTA_W-1:0] delta_q;
	logic signed [sdftlp_pkg::BIN_W-1:0]   a_q, b_q, re_q, im_q;
	logic signed [sdftlp_pkg::PROD_W-1:0]  prod_q, t_q;
	logic signed [sdftlp_pkg::ACC_W-1:0]   acc_q;
	logic signed [sdftlp_pkg::SMP_W-1:0]   res_q;
	logic signed [sdftlp_pkg::SMP_W-1:0]   filtered_q;

	// Handshake and RAM controls
	logic                                in_acc;
	logic                                axis_ok;
	logic                                out_load;
	logic                                hist_re, hist_we;
	logic [sdftlp_pkg::HIST_AW-1:0]      hist_raddr;
	logic [sdftlp_pkg::SMP_W-1:0]        hist_rdata;
	logic                                bin_re, bin_we;
	logic [sdftlp_pkg::BIN_AW-1:0]       bin_raddr, bin_waddr;
	logic [2*sdftlp_pkg::BIN_W-1:0]      bin_wdata, bin_rdata;

	// Datapath nets
	logic signed [sdftlp_pkg::SMP_W-1:0]   hist_old;
	logic signed [sdftlp_pkg::DELTA_W-1:0] delta_d;
	logic signed [sdftlp_pkg::BIN_W-1:0]   rd_re, rd_im, a_d, re0_d;
	logic signed [sdftlp_pkg::TW_W-1:0]    tw_c, tw_s, mul_y;
	logic signed [sdftlp_pkg::BIN_W-1:0]   mul_x;
	logic signed [sdftlp_pkg::PROD_W-1:0]  mul_p;
	logic signed [RND_W-1:0]               rnd_sum, rnd_bias;
	logic signed [RND_W-1:0]               rnd_sh;
	logic signed [sdftlp_pkg::BIN_W-1:0]   rnd_bin;
	logic signed [sdftlp_pkg::ACC_W-1:0]   acc_add;
	logic signed [FIN_W-1:0]               fin_sum, fin_sh;
	logic signed [sdftlp_pkg::SMP_W-1:0]   fin_sat;

	assign in_acc  = in_valid && in_ready;
	assign axis_ok = axis < sdftlp_pkg::AXIS_W'(sdftlp_pkg::AXES);

	// History samples, one per axis and window position
	sdftlp_ram #(
		.WIDTH(sdftlp_pkg::SMP_W),
		.DEPTH(sdftlp_pkg::HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hidx_q),
		.wdata (smp_q),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// Complex bins, real part on top
	sdftlp_ram #(
		.WIDTH(2 * sdftlp_pkg::BIN_W),
		.DEPTH(sdftlp_pkg::BIN_DEPTH)
	) u_bin_ram (
		.clk   (clk),
		.we    (bin_we),
		.waddr (bin_waddr),
		.wdata (bin_wdata),
		.re    (bin_re),
		.raddr (bin_raddr),
		.rdata (bin_rdata)
	);

	// Mask entries never written since reset to zero
	always_comb begin
		hist_old = hist_vld_q[hidx_q] ? hist_rdata : '0;
		if (bin_vld_q[baddr_q]) begin
			rd_re = bin_rdata[2*sdftlp_pkg::BIN_W-1:sdftlp_pkg::BIN_W];
			rd_im = bin_rdata[sdftlp_pkg::BIN_W-1:0];
		end else begin
			rd_re = '0;
			rd_im = '0;
		end
	end

	// Form delta and the bin-plus-delta sums
	always_comb begin
		delta_d = sdftlp_pkg::DELTA_W'(signed'({smp_q[sdftlp_pkg::SMP_W-1], smp_q})
			- signed'({hist_old[sdftlp_pkg::SMP_W-1], hist_old})) <<< 8;
		re0_d = sat_bin(SAT_W'(rd_re) + SAT_W'(delta_d));
		a_d   = sat_bin(SAT_W'(rd_re) + SAT_W'(delta_q));
	end

	// Select operands of the shared multiplier
	assign tw_c = sdftlp_pkg::tw_cos(k_q);
	assign tw_s = sdftlp_pkg::tw_sin(k_q);

	always_comb begin
		unique case (state_q)
			sdftlp_pkg::ST_P_AC: begin mul_x = a_q;  mul_y = tw_c; end
			sdftlp_pkg::ST_P_BD: begin mul_x = b_q;  mul_y = tw_s; end
			sdftlp_pkg::ST_P_AD: begin mul_x = a_q;  mul_y = tw_s; end
			sdftlp_pkg::ST_P_BC: begin mul_x = b_q;  mul_y = tw_c; end
			sdftlp_pkg::ST_P_RC: begin mul_x = re_q; mul_y = tw_c; end
			sdftlp_pkg::ST_P_ID: begin mul_x = im_q; mul_y = tw_s; end
			default:             begin mul_x = a_q;  mul_y = tw_c; end
		endcase
	end

	assign mul_p = sdftlp_pkg::PROD_W'(mul_x) * sdftlp_pkg::PROD_W'(mul_y);

	// Round a product pair back to Q8 and clamp; add the doubled product to the accumulator
	always_comb begin
		if (state_q == sdftlp_pkg::ST_P_AD) begin
			rnd_sum = RND_W'(t_q) - RND_W'(prod_q);
		end else begin
			rnd_sum = RND_W'(t_q) + RND_W'(prod_q);
		end
		rnd_bias = rnd_sum + RND_W'(16384);
		rnd_sh   = rnd_bias >>> 15;
		rnd_bin  = sat_bin(rnd_sh[SAT_W-1:0]);
		acc_add  = acc_q + (sdftlp_pkg::ACC_W'(prod_q) <<< 1);
	end

	// Divide by the window with round half up, then clamp to 16 bits
	always_comb begin
		fin_sum = FIN_W'(acc_q) + FIN_W'(64'sd134217728);
		fin_sh  = fin_sum >>> 28;
		if (fin_sh > FIN_W'(32767)) begin
			fin_sat = 16'sd32767;
		end else if (fin_sh < -FIN_W'(32768)) begin
			fin_sat = -16'sd32768;
		end else begin
			fin_sat = fin_sh[sdftlp_pkg::SMP_W-1:0];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdftlp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and RAM strobes
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		hist_re    = 1'b0;
		hist_we    = 1'b0;
		hist_raddr = {axis, position_q};
		bin_re     = 1'b0;
		bin_raddr  = {axis, sdftlp_pkg::BIN_IDX_W'(0)};
		bin_we     = 1'b0;
		bin_waddr  = {axis_q, k_q};
		bin_wdata  = {re_q, im_q};
		unique case (state_q)
			sdftlp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					hist_re = axis_ok;
					bin_re  = axis_ok;
					state_d = axis_ok ? sdftlp_pkg::ST_HIST : sdftlp_pkg::ST_DONE;
				end
			end
			sdftlp_pkg::ST_HIST: begin
				hist_we   = 1'b1;
				bin_we    = 1'b1;
				bin_waddr = {axis_q, sdftlp_pkg::BIN_IDX_W'(0)};
				bin_wdata = {re0_d, rd_im};
				bin_re    = 1'b1;
				bin_raddr = {axis_q, sdftlp_pkg::BIN_IDX_W'(1)};
				state_d   = (hb_q == 3'd0) ? sdftlp_pkg::ST_ROUND : sdftlp_pkg::ST_LOAD;
			end
			sdftlp_pkg::ST_LOAD: state_d = sdftlp_pkg::ST_P_AC;
			sdftlp_pkg::ST_P_AC: state_d = sdftlp_pkg::ST_P_BD;
			sdftlp_pkg::ST_P_BD: state_d = sdftlp_pkg::ST_P_AD;
			sdftlp_pkg::ST_P_AD: state_d = sdftlp_pkg::ST_P_BC;
			sdftlp_pkg::ST_P_BC: state_d = sdftlp_pkg::ST_P_RC;
			sdftlp_pkg::ST_P_RC: state_d = sdftlp_pkg::ST_P_ID;
			sdftlp_pkg::ST_P_ID: begin
				bin_we  = 1'b1;
				state_d = sdftlp_pkg::ST_ACC;
			end
			sdftlp_pkg::ST_ACC: begin
				if (k_q == hb_q) begin
					state_d = sdftlp_pkg::ST_ROUND;
				end else begin
					bin_re    = 1'b1;
					bin_raddr = {axis_q, k_q + sdftlp_pkg::BIN_IDX_W'(1)};
					state_d   = sdftlp_pkg::ST_LOAD;
				end
			end
			sdftlp_pkg::ST_ROUND: state_d = sdftlp_pkg::ST_DONE;
			sdftlp_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = sdftlp_pkg::ST_IDLE;
				end
			end
			default: state_d = sdftlp_pkg::ST_IDLE;
		endcase
	end

	// Control state: register, window position, valid bits, output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_bin_q <= 3'd2;
			position_q    <= '0;
			hist_vld_q    <= '0;
			bin_vld_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				highest_bin_q <= cfg_wdata;
			end
			if (hist_we) begin
				hist_vld_q[hidx_q] <= 1'b1;
			end
			if (bin_we) begin
				bin_vld_q[bin_waddr] <= 1'b1;
			end
			// Advance the window after the last axis
			if (state_q == sdftlp_pkg::ST_HIST
				&& axis_q == sdftlp_pkg::AXIS_W'(sdftlp_pkg::AXES - 1)) begin
				if (position_q == sdftlp_pkg::POS_W'(sdftlp_pkg::WINDOW - 1)) begin
					position_q <= '0;
				end else begin
					position_q <= position_q + sdftlp_pkg::POS_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, stepped by the sequencer
	always_ff @(posedge clk) begin
		if (bin_re) begin
			baddr_q <= bin_raddr;
		end
		if (out_load) begin
			filtered_q <= res_q;
		end
		unique case (state_q)
			sdftlp_pkg::ST_IDLE: begin
				if (in_acc) begin
					smp_q  <= sample;
					axis_q <= axis;
					hb_q   <= highest_bin_q;
					hidx_q <= {axis, position_q};
					res_q  <= '0;
				end
			end
			sdftlp_pkg::ST_HIST: begin
				delta_q <= delta_d;
				acc_q   <= sdftlp_pkg::ACC_W'(re0_d) <<< 15;
				k_q     <= sdftlp_pkg::BIN_IDX_W'(1);
			end
			sdftlp_pkg::ST_LOAD: begin
				a_q <= a_d;
				b_q <= rd_im;
			end
			sdftlp_pkg::ST_P_AC: prod_q <= mul_p;
			sdftlp_pkg::ST_P_BD: begin
				prod_q <= mul_p;
				t_q    <= prod_q;
			end
			sdftlp_pkg::ST_P_AD: begin
				prod_q <= mul_p;
				re_q   <= rnd_bin;
			end
			sdftlp_pkg::ST_P_BC: begin
				prod_q <= mul_p;
				t_q    <= prod_q;
			end
			sdftlp_pkg::ST_P_RC: begin
				prod_q <= mul_p;
				im_q   <= rnd_bin;
			end
			sdftlp_pkg::ST_P_ID: begin
				prod_q <= mul_p;
				acc_q  <= acc_add;
			end
			sdftlp_pkg::ST_ACC: begin
				acc_q <= acc_add;
				if (k_q != hb_q) begin
					k_q <= k_q + sdftlp_pkg::BIN_IDX_W'(1);
				end
			end
			sdftlp_pkg::ST_ROUND: res_q <= fin_sat;
			sdftlp_pkg::ST_DONE: begin
				// hold until the output register frees
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule
